// ----- sv/dltq_pkg.sv -----
package dltq_pkg;

	// Default number of queue slots
	localparam int QUEUE_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_DISPATCH = 2'd2,
		MODE_DELETE   = 2'd3
	} mode_t;

	// Request transfer payload
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  task_id;
		logic [15:0] delay;
		logic [15:0] period;
		logic [3:0]  slot_index;
	} req_t;

	// Response transfer payload
	typedef struct packed {
		logic [4:0] insert_slot;
		logic       fired;
		logic [7:0] fired_task;
	} rsp_t;

	// One stored queue entry
	typedef struct packed {
		logic [7:0]  task_id;
		logic [15:0] delta;
		logic [15:0] period;
		logic [7:0]  run_count;
	} entry_t;

	// Controller to datapath strobes
	typedef struct packed {
		logic accept;
		logic tick;
		logic walk;
		logic ash_start;
		logic ashift;
		logic ains;
		logic del_rd;
		logic pop;
		logic dshift;
		logic readd;
		logic finish;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic full;
		logic walk_adv;
		logic walk_end;
		logic del_ok;
		logic has_next;
		logic due;
		logic head_rep;
		logic ash_more;
		logic dsh_more;
		logic rep;
		logic disp;
		logic out_free;
	} ctl_sts_t;

endpackage

// ----- sv/dltq_ram.sv -----
module dltq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/dltq_ctrl.sv -----
module dltq_ctrl import dltq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  mode_t    req_mode,
	output logic     req_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_TICK    = 11'b000_0000_0010,
		S_WALK    = 11'b000_0000_0100,
		S_ASH_ST  = 11'b000_0000_1000,
		S_ASHIFT  = 11'b000_0001_0000,
		S_AINS    = 11'b000_0010_0000,
		S_DEL     = 11'b000_0100_0000,
		S_DISP    = 11'b000_1000_0000,
		S_DSHIFT  = 11'b001_0000_0000,
		S_READD   = 11'b010_0000_0000,
		S_DONE    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// Sequencing of one operation
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (req_mode)
						MODE_TICK:     state_d = S_TICK;
						MODE_ADD:      state_d = sts.full ? S_DONE : S_WALK;
						MODE_DISPATCH: state_d = S_DISP;
						MODE_DELETE:   state_d = S_DEL;
						default:       state_d = S_DONE;
					endcase
				end
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				state_d  = S_DONE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (!sts.walk_adv) begin
					state_d = sts.walk_end ? S_AINS : S_ASH_ST;
				end
			end
			S_ASH_ST: begin
				cmd.ash_start = 1'b1;
				state_d       = S_ASHIFT;
			end
			S_ASHIFT: begin
				cmd.ashift = 1'b1;
				if (!sts.ash_more) begin
					state_d = S_AINS;
				end
			end
			S_AINS: begin
				cmd.ains = 1'b1;
				state_d  = S_DONE;
			end
			S_DEL: begin
				if (sts.del_ok) begin
					cmd.del_rd = 1'b1;
					state_d    = sts.has_next ? S_DSHIFT : S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DISP: begin
				if (sts.due) begin
					cmd.del_rd = 1'b1;
					cmd.pop    = 1'b1;
					if (sts.has_next) begin
						state_d = S_DSHIFT;
					end else begin
						state_d = sts.head_rep ? S_READD : S_DONE;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_DSHIFT: begin
				cmd.dshift = 1'b1;
				if (!sts.dsh_more) begin
					state_d = (sts.disp && sts.rep) ? S_READD : S_DONE;
				end
			end
			S_READD: begin
				cmd.readd = 1'b1;
				state_d   = S_WALK;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/dltq_dpath.sv -----
module dltq_dpath import dltq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	output rsp_t     rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int XW = ((CW > 4) ? CW : 4) + 2;

	// Entry store
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic [AW-1:0] rd_addr;
	entry_t        rd_entry;

	dltq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	// Control registers
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	// Operation registers
	mode_t         mode_q;
	logic [CW-1:0] pos_q;
	logic [15:0]   rest_q;
	logic [CW-1:0] j_q;
	logic [3:0]    idx_q;
	logic [15:0]   removed_q;
	logic [7:0]    add_task_q;
	logic [15:0]   add_delay_q;
	logic [15:0]   add_period_q;
	logic [4:0]    slot_q;
	logic          fired_q;
	logic [7:0]    fired_task_q;
	rsp_t          rsp_q;

	logic [XW-1:0] count_x, idx_x, j_x, pos_x;
	logic          empty;
	logic [16:0]   fold_sum;
	entry_t        ticked, fixed_up, folded, fresh;

	assign count_x = XW'(count_q);
	assign idx_x   = XW'(idx_q);
	assign j_x     = XW'(j_q);
	assign pos_x   = XW'(pos_q);
	assign empty   = (count_q == '0);

	// Status toward the controller
	always_comb begin
		sts          = '0;
		sts.full     = (count_q == CW'(QUEUE_DEPTH));
		sts.walk_adv = (pos_q < count_q) && (rd_entry.delta <= rest_q);
		sts.walk_end = (pos_q == count_q);
		sts.del_ok   = (idx_x < count_x);
		sts.has_next = ((idx_x + XW'(1)) < count_x);
		sts.due      = !empty && (rd_entry.run_count != 8'd0);
		sts.head_rep = (rd_entry.period != 16'd0);
		sts.ash_more = (j_x > (pos_x + XW'(1)));
		sts.dsh_more = ((j_x + XW'(2)) < count_x);
		sts.rep      = (add_period_q != 16'd0);
		sts.disp     = (mode_q == MODE_DISPATCH);
		sts.out_free = !rsp_valid_q || rsp_ready;
	end

	// Entry updates
	always_comb begin
		ticked = rd_entry;
		if (rd_entry.delta == 16'd0) begin
			if (rd_entry.run_count != 8'hFF) begin
				ticked.run_count = rd_entry.run_count + 8'd1;
			end
		end else begin
			ticked.delta = rd_entry.delta - 16'd1;
		end

		fixed_up = rd_entry;
		if (j_x == (pos_x + XW'(1))) begin
			fixed_up.delta = rd_entry.delta - rest_q;
		end

		fold_sum = {1'b0, rd_entry.delta} + {1'b0, removed_q};
		folded   = rd_entry;
		if (j_x == idx_x) begin
			folded.delta = fold_sum[16] ? 16'hFFFF : fold_sum[15:0];
		end

		fresh.task_id   = add_task_q;
		fresh.delta     = rest_q;
		fresh.period    = add_period_q;
		fresh.run_count = 8'd0;
	end

	// Store port selection
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_entry = rd_entry;
		rd_addr  = '0;
		if (cmd.accept && (req.mode == MODE_DELETE)) begin
			rd_addr = AW'(req.slot_index);
		end
		if (cmd.tick && !empty) begin
			wr_en    = 1'b1;
			wr_entry = ticked;
		end
		if (cmd.walk && sts.walk_adv) begin
			rd_addr = AW'(pos_q + CW'(1));
		end
		if (cmd.ash_start) begin
			rd_addr = AW'(count_q - CW'(1));
		end
		if (cmd.ashift) begin
			wr_en    = 1'b1;
			wr_addr  = AW'(j_q);
			wr_entry = fixed_up;
			if (sts.ash_more) begin
				rd_addr = AW'(j_q - CW'(2));
			end
		end
		if (cmd.ains) begin
			wr_en    = 1'b1;
			wr_addr  = AW'(pos_q);
			wr_entry = fresh;
		end
		if (cmd.del_rd && sts.has_next) begin
			rd_addr = AW'(idx_x + XW'(1));
		end
		if (cmd.dshift) begin
			wr_en    = 1'b1;
			wr_addr  = AW'(j_q);
			wr_entry = folded;
			if (sts.dsh_more) begin
				rd_addr = AW'(j_x + XW'(2));
			end
		end
	end

	// Fill count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ains) begin
				count_q <= count_q + CW'(1);
			end else if ((cmd.del_rd && !sts.has_next) || (cmd.dshift && !sts.dsh_more)) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Walk, shift and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q       <= req.mode;
			add_task_q   <= req.task_id;
			add_delay_q  <= req.delay;
			add_period_q <= req.period;
			idx_q        <= (req.mode == MODE_DISPATCH) ? 4'd0 : req.slot_index;
			pos_q        <= '0;
			rest_q       <= req.delay;
			fired_q      <= 1'b0;
			fired_task_q <= 8'd0;
			slot_q       <= ((req.mode == MODE_ADD) && sts.full) ? 5'(QUEUE_DEPTH) : 5'd0;
		end
		if (cmd.walk && sts.walk_adv) begin
			rest_q <= rest_q - rd_entry.delta;
			pos_q  <= pos_q + CW'(1);
		end
		if (cmd.ash_start) begin
			j_q <= count_q;
		end
		if (cmd.ashift) begin
			j_q <= j_q - CW'(1);
		end
		if (cmd.ains && (mode_q == MODE_ADD)) begin
			slot_q <= 5'(pos_q);
		end
		if (cmd.del_rd) begin
			removed_q <= rd_entry.delta;
			j_q       <= CW'(idx_q);
		end
		if (cmd.pop) begin
			fired_q      <= 1'b1;
			fired_task_q <= rd_entry.task_id;
			add_task_q   <= rd_entry.task_id;
			add_delay_q  <= rd_entry.period;
			add_period_q <= rd_entry.period;
		end
		if (cmd.dshift) begin
			j_q <= j_q + CW'(1);
		end
		if (cmd.readd) begin
			pos_q  <= '0;
			rest_q <= add_delay_q;
		end
		if (cmd.finish) begin
			rsp_q.insert_slot <= slot_q;
			rsp_q.fired       <= fired_q;
			rsp_q.fired_task  <= fired_task_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sv/delta_list_task_timer_queue.sv -----
// Delta-list timer queue: one request in work at a time, one entry per cycle through the store.
// Steps per request: tick updates the head entry; add walks, shifts up and inserts, and a refused
// add goes straight to the response; delete shifts down; dispatch pops, shifts down and walks.
// The next request is taken the cycle after the response is loaded, so a new request waits until
// the last one is through, longer while rsp_ready holds a response; the one-read store sets the pace.
// Reset clears the controller, fill count and response valid; the entry store is not cleared.
module delta_list_task_timer_queue import dltq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	dltq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dltq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
